[rtl/gng_pkg.sv]
// Shared widths, register indexes, direction masks and types of the grid neighbour generator.
package gng_pkg;

    localparam int NODE_W      = 20;
    localparam int EDGE_W      = 23;
    localparam int DIR_W       = 3;
    localparam int NUM_DIRS    = 8;
    localparam int CFG_W       = 11;
    localparam int CFG_IDX_W   = 3;
    localparam int MAX_SIDE_DEF = 1024;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EIGHT_NBR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTED    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP        = 3'd4;

    // Bit d of each mask stands for direction d (0 nw, 1 n, 2 ne, 3 w, 4 e, 5 sw, 6 s, 7 se).
    localparam logic [NUM_DIRS-1:0] UP_DIRS    = 8'b0000_0111;
    localparam logic [NUM_DIRS-1:0] DOWN_DIRS  = 8'b1110_0000;
    localparam logic [NUM_DIRS-1:0] LEFT_DIRS  = 8'b0010_1001;
    localparam logic [NUM_DIRS-1:0] RIGHT_DIRS = 8'b1001_0100;

    localparam logic [NUM_DIRS-1:0] SEL_EIGHT_ALL  = 8'b1111_1111;
    localparam logic [NUM_DIRS-1:0] SEL_EIGHT_BACK = 8'b0000_1111;
    localparam logic [NUM_DIRS-1:0] SEL_FOUR_ALL   = 8'b0101_1010;
    localparam logic [NUM_DIRS-1:0] SEL_FOUR_BACK  = 8'b0000_1010;

    typedef struct packed {
        logic busy;
        logic done;
    } gng_div_stat_t;

endpackage

[rtl/gng_node_if.sv]
// Input channel carrying one node index per transfer.
interface gng_node_if
    import gng_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [NODE_W-1:0] node_index;
    logic              start_pass;

    modport source (output valid, output node_index, output start_pass, input ready);
    modport sink   (input valid, input node_index, input start_pass, output ready);
endinterface

[rtl/gng_link_if.sv]
// Output channel carrying one neighbour edge per transfer.
interface gng_link_if
    import gng_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [NODE_W-1:0] neighbour_index;
    logic [DIR_W-1:0]  direction;
    logic [EDGE_W-1:0] edge_number;
    logic              last_of_node;

    modport source (output valid, output neighbour_index, output direction,
                    output edge_number, output last_of_node, input ready);
    modport sink   (input valid, input neighbour_index, input direction,
                    input edge_number, input last_of_node, output ready);
endinterface

[rtl/gng_div.sv]
// Restoring divider that produces one quotient bit per cycle.
module gng_div
    import gng_pkg::*;
#(
    parameter int DIVISOR_W = 11
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [NODE_W-1:0]    dividend,
    input  logic [DIVISOR_W-1:0] divisor,
    output gng_div_stat_t        stat,
    output logic [NODE_W-1:0]    quotient,
    output logic [DIVISOR_W-1:0] remainder
);

    localparam int CNT_W = $clog2(NODE_W + 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [NODE_W-1:0]    dq_reg, dq_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [DIVISOR_W-1:0] dvs_reg, dvs_next;
    logic [DIVISOR_W:0]   trial;
    logic [DIVISOR_W:0]   diff;
    logic                 fits;

    // The dividend shifts out at the top while quotient bits shift in at the bottom.
    assign trial = {rem_reg, dq_reg[NODE_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NODE_W);
            dq_next   = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            dq_next  = {dq_reg[NODE_W-2:0], fits};
            rem_next = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = dq_reg;
    assign remainder = rem_reg;

endmodule

[rtl/grid_neighbour_generator_unit.sv]
// A node is split into row and column by a bit-serial divider, then its neighbours are
// loaded one by one into the output register.
// A new node is taken only once every result of the last node is in the output register;
// results leave one per cycle while the sink is ready.
// Reset: clears the edge counter, the sequencer and the output valid, and sets the
// registers to width 1, height 1, four neighbours, backward half, fixed borders.
module grid_neighbour_generator_unit
    import gng_pkg::*;
#(
    parameter int MAX_SIDE = MAX_SIDE_DEF
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    gng_node_if.sink             nodes,
    gng_link_if.source           links
);

    localparam int CLAMP_SIDE = (MAX_SIDE > 2047) ? 2047 : MAX_SIDE;
    localparam int SIDE_W     = $clog2(CLAMP_SIDE + 1);
    localparam int PROD_W     = 2 * SIDE_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [CFG_W-1:0]    width_cfg_reg, height_cfg_reg;
    logic                eight_reg, directed_reg, wrap_reg;
    logic [SIDE_W-1:0]   side_w, side_h;
    logic [PROD_W-1:0]   last_prod;
    logic [NODE_W-1:0]   last_base_reg;

    logic [1:0]          state_reg, state_next;
    logic [NODE_W-1:0]   node_reg;
    logic [EDGE_W-1:0]   edge_count_reg, edge_count_next;
    logic [NUM_DIRS-1:0] mask_reg, mask_next;
    logic [NODE_W-1:0]   base_up_reg, base_mid_reg, base_down_reg;
    logic [SIDE_W-1:0]   col_left_reg, col_mid_reg, col_right_reg;

    logic                out_valid_reg, out_valid_next;
    logic [NODE_W-1:0]   out_index_reg;
    logic [DIR_W-1:0]    out_dir_reg;
    logic [EDGE_W-1:0]   out_edge_reg;
    logic                out_last_reg;

    logic                accept, load_out, prep;
    gng_div_stat_t       div_stat;
    logic [NODE_W-1:0]   row;
    logic [SIDE_W-1:0]   col;
    logic [NODE_W-1:0]   row_base;
    logic                top_row, bottom_row, left_col, right_col, outside;
    logic [NUM_DIRS-1:0] sel, prep_mask;
    logic [DIR_W-1:0]    pick_dir;
    logic [NUM_DIRS-1:0] pick_bit;
    logic [NODE_W-1:0]   pick_base;
    logic [SIDE_W-1:0]   pick_col;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= CFG_W'(1);
            height_cfg_reg <= CFG_W'(1);
            eight_reg      <= 1'b0;
            directed_reg   <= 1'b0;
            wrap_reg       <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_GRID_WIDTH:  width_cfg_reg  <= cfg_data;
                CFG_GRID_HEIGHT: height_cfg_reg <= cfg_data;
                CFG_EIGHT_NBR:   eight_reg      <= cfg_data[0];
                CFG_DIRECTED:    directed_reg   <= cfg_data[0];
                CFG_WRAP:        wrap_reg       <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // A side of zero counts as one, and a side above the limit is cut to it.
    always_comb
    begin
        if (width_cfg_reg == '0)
            side_w = SIDE_W'(1);
        else if (width_cfg_reg > CFG_W'(CLAMP_SIDE))
            side_w = SIDE_W'(CLAMP_SIDE);
        else
            side_w = SIDE_W'(width_cfg_reg);
        if (height_cfg_reg == '0)
            side_h = SIDE_W'(1);
        else if (height_cfg_reg > CFG_W'(CLAMP_SIDE))
            side_h = SIDE_W'(CLAMP_SIDE);
        else
            side_h = SIDE_W'(height_cfg_reg);
    end

    // Start of the last row; configuration is static long before a node needs it.
    assign last_prod = (side_h - 1'b1) * side_w;

    always_ff @(posedge clk)
    begin
        last_base_reg <= NODE_W'(last_prod);
    end

    assign accept = nodes.valid && nodes.ready;

    gng_div #(
        .DIVISOR_W (SIDE_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept),
        .dividend  (nodes.node_index),
        .divisor   (side_w),
        .stat      (div_stat),
        .quotient  (row),
        .remainder (col)
    );

    // Border flags and neighbour bases, worked out in the cycle the divider finishes.
    assign prep       = (state_reg == ST_DIV) && div_stat.done;
    assign row_base   = node_reg - NODE_W'(col);
    assign outside    = (row >= NODE_W'(side_h));
    assign top_row    = (row == '0);
    assign bottom_row = (row == NODE_W'(side_h - 1'b1));
    assign left_col   = (col == '0);
    assign right_col  = (col == side_w - 1'b1);

    always_comb
    begin
        case ({eight_reg, directed_reg})
            2'b11:   sel = SEL_EIGHT_ALL;
            2'b10:   sel = SEL_EIGHT_BACK;
            2'b01:   sel = SEL_FOUR_ALL;
            default: sel = SEL_FOUR_BACK;
        endcase
        prep_mask = sel;
        if (!wrap_reg)
        begin
            if (top_row)    prep_mask = prep_mask & ~UP_DIRS;
            if (bottom_row) prep_mask = prep_mask & ~DOWN_DIRS;
            if (left_col)   prep_mask = prep_mask & ~LEFT_DIRS;
            if (right_col)  prep_mask = prep_mask & ~RIGHT_DIRS;
        end
        if (outside)
            prep_mask = '0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            node_reg <= nodes.node_index;
        if (prep)
        begin
            base_up_reg   <= top_row ? last_base_reg : row_base - NODE_W'(side_w);
            base_mid_reg  <= row_base;
            base_down_reg <= bottom_row ? '0 : row_base + NODE_W'(side_w);
            col_left_reg  <= left_col ? side_w - 1'b1 : col - 1'b1;
            col_mid_reg   <= col;
            col_right_reg <= right_col ? '0 : col + 1'b1;
        end
    end

    // Lowest pending direction goes out first, which gives the fixed order.
    always_comb
    begin
        pick_dir = '0;
        for (int i = NUM_DIRS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
                pick_dir = DIR_W'(i);
        end
        pick_bit = NUM_DIRS'(1) << pick_dir;
        if ((UP_DIRS & pick_bit) != '0)
            pick_base = base_up_reg;
        else if ((DOWN_DIRS & pick_bit) != '0)
            pick_base = base_down_reg;
        else
            pick_base = base_mid_reg;
        if ((LEFT_DIRS & pick_bit) != '0)
            pick_col = col_left_reg;
        else if ((RIGHT_DIRS & pick_bit) != '0)
            pick_col = col_right_reg;
        else
            pick_col = col_mid_reg;
    end

    assign load_out = (state_reg == ST_EMIT) && (mask_reg != '0)
                      && (!out_valid_reg || links.ready);

    always_comb
    begin
        state_next      = state_reg;
        mask_next       = mask_reg;
        edge_count_next = edge_count_reg;
        out_valid_next  = out_valid_reg;
        if (out_valid_reg && links.ready)
            out_valid_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_DIV;
                    if (nodes.start_pass)
                        edge_count_next = '0;
                end
            end
            ST_DIV:
            begin
                if (prep)
                begin
                    state_next = ST_EMIT;
                    mask_next  = prep_mask;
                end
            end
            ST_EMIT:
            begin
                if (mask_reg == '0)
                    state_next = ST_IDLE;
                else if (load_out)
                begin
                    mask_next       = mask_reg & ~pick_bit;
                    edge_count_next = edge_count_reg + 1'b1;
                    out_valid_next  = 1'b1;
                    if ((mask_reg & ~pick_bit) == '0)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                mask_next  = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            mask_reg       <= '0;
            edge_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mask_reg       <= mask_next;
            edge_count_reg <= edge_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_index_reg <= pick_base + NODE_W'(pick_col);
            out_dir_reg   <= pick_dir;
            out_edge_reg  <= edge_count_reg;
            out_last_reg  <= ((mask_reg & ~pick_bit) == '0);
        end
    end

    assign nodes.ready           = (state_reg == ST_IDLE);
    assign links.valid           = out_valid_reg;
    assign links.neighbour_index = out_index_reg;
    assign links.direction       = out_dir_reg;
    assign links.edge_number     = out_edge_reg;
    assign links.last_of_node    = out_last_reg;

    // A result that is not the last one means more directions of the node are pending.
    a_more_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (links.valid && !links.last_of_node) |-> (state_reg == ST_EMIT && mask_reg != '0))
        else $error("non-final result without pending directions");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide state");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> (edge_count_reg == $past(edge_count_reg) + 1'b1))
        else $error("edge counter did not advance by one per result");

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (mask_reg == '0 && !div_stat.busy))
        else $error("idle with work still pending");

endmodule

[tb/sv/grid_neighbour_generator_unit_test.sv]
// Self-checking testbench of the grid neighbour generator: directed table, then random phases.
`timescale 1ns / 100ps

module grid_neighbour_generator_unit_test;
    import gng_pkg::*;

    typedef enum logic [DIR_W-1:0] {
        NB_NW, NB_N, NB_NE, NB_W, NB_E, NB_SW, NB_S, NB_SE
    } dir_e;

    typedef struct packed {
        logic [NODE_W-1:0] nbr;
        logic [DIR_W-1:0]  dir;
        logic [EDGE_W-1:0] edge_num;
        logic              last;
    } link_t;

    // One row of the directed table; n_typed below zero means the predictor decides.
    typedef struct packed {
        logic [CFG_W-1:0]  gw;
        logic [CFG_W-1:0]  gh;
        logic              eight;
        logic              directed;
        logic              wrap;
        logic [NODE_W-1:0] node;
        logic              start;
        int                n_typed;
    } stim_row_t;

    localparam dir_e FOUR_ORDER [4] = '{NB_N, NB_W, NB_E, NB_S};
    localparam int   SEND_IDLE  [4] = '{0, 66, 0, 14};
    localparam int   RECV_STALL [4] = '{0, 0, 66, 14};
    localparam int   QUIET_CYCLES   = 40;
    localparam int   HOLD_CYCLES    = 300;
    localparam int   RANDOM_PHASES  = 8;
    localparam int   NODES_PER_PHASE = 31;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_write_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    gng_node_if node_ch ();
    gng_link_if link_ch ();

    grid_neighbour_generator_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .nodes        (node_ch),
        .links        (link_ch)
    );

    always #5 clk = ~clk;

    // Register copies and edge counter of the predictor.
    logic [CFG_W-1:0]  cfg_width    = 1;
    logic [CFG_W-1:0]  cfg_height   = 1;
    logic              cfg_eight    = 1'b0;
    logic              cfg_directed = 1'b0;
    logic              cfg_wrap     = 1'b0;
    logic [EDGE_W-1:0] edge_count   = '0;

    link_t fresh_links[$];
    link_t typed_links[$];
    link_t expected_links[$];
    int    mismatches = 0;

    int    sender_idle_pct = 0;
    int    stall_pct = 0;
    bit    hold_req = 1'b0;
    logic  hold_on = 1'b0;

    function automatic int unsigned side_of(input logic [CFG_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_SIDE_DEF)
            return MAX_SIDE_DEF;
        return v;
    endfunction

    function automatic int offset_of(input dir_e d, input bit vertical);
        if (vertical)
        begin
            case (d)
                NB_NW, NB_N, NB_NE: return -1;
                NB_SW, NB_S, NB_SE: return 1;
                default:            return 0;
            endcase
        end
        case (d)
            NB_NW, NB_W, NB_SW: return -1;
            NB_NE, NB_E, NB_SE: return 1;
            default:            return 0;
        endcase
    endfunction

    // Steps one coordinate; a step off the side fails unless borders wrap.
    function automatic bit step_along(input int unsigned pos, input int off,
                                      input int unsigned len, output int unsigned dst);
        dst = pos;
        if (off < 0)
        begin
            if (pos == 0)
            begin
                if (!cfg_wrap)
                    return 1'b0;
                dst = len - 1;
            end
            else
                dst = pos - 1;
        end
        else if (off > 0)
        begin
            if (pos + 1 >= len)
            begin
                if (!cfg_wrap)
                    return 1'b0;
                dst = 0;
            end
            else
                dst = pos + 1;
        end
        return 1'b1;
    endfunction

    // Appends the links of one node to fresh_links and advances the edge counter.
    function automatic void predict_links(input logic [NODE_W-1:0] node, input logic start);
        int unsigned ew, eh, row, col, nr, nc, span;
        dir_e        d;
        ew = side_of(cfg_width);
        eh = side_of(cfg_height);
        if (start)
            edge_count = '0;
        row = node / ew;
        col = node % ew;
        if (row >= eh)
            return;
        if (cfg_eight)
            span = cfg_directed ? 8 : 4;
        else
            span = cfg_directed ? 4 : 2;
        for (int i = 0; i < span; i++)
        begin
            d = cfg_eight ? dir_e'(i) : FOUR_ORDER[i];
            if (step_along(row, offset_of(d, 1'b1), eh, nr) &&
                step_along(col, offset_of(d, 1'b0), ew, nc))
            begin
                fresh_links.push_back('{NODE_W'(nr * ew + nc), d, edge_count, 1'b0});
                edge_count = edge_count + 1'b1;
            end
        end
        if (fresh_links.size() != 0)
            fresh_links[fresh_links.size() - 1].last = 1'b1;
    endfunction

    function automatic void log_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%t: %s", $realtime, msg);
    endfunction

    always @(posedge clk)
    begin : watch_links
        link_t got;
        link_t want;
        if (rst_n && link_ch.valid && link_ch.ready)
        begin
            got = '{link_ch.neighbour_index, link_ch.direction,
                    link_ch.edge_number, link_ch.last_of_node};
            if (expected_links.size() == 0)
                log_mismatch($sformatf("unexpected link: nbr %0d dir %0d edge %0d last %0d",
                                       got.nbr, got.dir, got.edge_num, got.last));
            else
            begin
                want = expected_links.pop_front();
                if (got.nbr !== want.nbr || got.dir !== want.dir ||
                    got.edge_num !== want.edge_num || got.last !== want.last)
                    log_mismatch($sformatf(
                        "link: expected nbr %0d dir %0d edge %0d last %0d, got %0d %0d %0d %0d",
                        want.nbr, want.dir, want.edge_num, want.last,
                        got.nbr, got.dir, got.edge_num, got.last));
            end
        end
    end

    always @(posedge clk)
        link_ch.ready <= !hold_on && ($urandom_range(99) >= stall_pct);

    // Long receiver hold-off while the sender keeps offering nodes.
    initial
    begin : hold_off
        wait (hold_req);
        @(posedge clk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on <= 1'b0;
    end

    initial
    begin : limit
        #3_000_000;
        $display("grid_neighbour_generator_unit_test failed");
        $finish;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= data;
        @(posedge clk);
    endtask

    task automatic apply_config(input logic [CFG_W-1:0] gw, input logic [CFG_W-1:0] gh,
                                input logic eight, input logic directed, input logic wrap);
        write_reg(CFG_GRID_WIDTH, gw);
        write_reg(CFG_GRID_HEIGHT, gh);
        write_reg(CFG_EIGHT_NBR, {{(CFG_W-1){1'b0}}, eight});
        write_reg(CFG_DIRECTED, {{(CFG_W-1){1'b0}}, directed});
        write_reg(CFG_WRAP, {{(CFG_W-1){1'b0}}, wrap});
        cfg_write_en <= 1'b0;
        cfg_width    = gw;
        cfg_height   = gh;
        cfg_eight    = eight;
        cfg_directed = directed;
        cfg_wrap     = wrap;
        @(posedge clk);
    endtask

    // Drops valid, waits for every expected link, then lets a node with no links finish.
    task automatic settle();
        node_ch.valid <= 1'b0;
        while (expected_links.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic offer_node(input logic [NODE_W-1:0] node, input logic start,
                              input int typed_n);
        if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct)
        begin
            node_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct);
        end
        node_ch.valid      <= 1'b1;
        node_ch.node_index <= node;
        node_ch.start_pass <= start;
        do
            @(posedge clk);
        while (!node_ch.ready);
        // The transfer happened at this edge.
        predict_links(node, start);
        if (typed_n < 0)
        begin
            foreach (fresh_links[k])
                expected_links.push_back(fresh_links[k]);
        end
        else
        begin
            repeat (typed_n)
                expected_links.push_back(typed_links.pop_front());
        end
        fresh_links.delete();
    endtask

    function automatic logic [CFG_W-1:0] pick_side();
        case ($urandom_range(0, 7))
            0:       return CFG_W'(0);
            1:       return CFG_W'(1);
            2:       return CFG_W'(1024);
            3:       return CFG_W'(2047);
            4:       return CFG_W'($urandom_range(0, 2047));
            default: return CFG_W'($urandom_range(2, 9));
        endcase
    endfunction

    function automatic logic [NODE_W-1:0] pick_node();
        int unsigned ew, area;
        ew   = side_of(cfg_width);
        area = ew * side_of(cfg_height);
        case ($urandom_range(0, 9))
            0:       return NODE_W'($urandom_range(0, 20'hFFFFF));
            1:       return NODE_W'(area - 1);
            2:       return NODE_W'(ew - 1);
            3:       return NODE_W'(area);
            default: return NODE_W'($urandom_range(0, area - 1));
        endcase
    endfunction

    initial
    begin : run
        stim_row_t plan[$];
        stim_row_t r;

        node_ch.valid      <= 1'b0;
        node_ch.node_index <= '0;
        node_ch.start_pass <= 1'b0;
        cfg_write_en       <= 1'b0;
        cfg_index          <= CFG_GRID_WIDTH;
        cfg_data           <= '0;

        // Registers after reset: a lone node has no neighbour, any other node is outside.
        plan.push_back('{11'd1, 11'd1, 1'b0, 1'b0, 1'b0, 20'd0, 1'b1, 0});
        plan.push_back('{11'd1, 11'd1, 1'b0, 1'b0, 1'b0, 20'hFFFFF, 1'b0, 0});
        // One node with wrapping borders links to itself in all eight directions.
        plan.push_back('{11'd1, 11'd1, 1'b1, 1'b1, 1'b1, 20'd0, 1'b1, 8});
        plan.push_back('{11'd1, 11'd1, 1'b1, 1'b1, 1'b1, 20'hFFFFF, 1'b0, 0});
        // Zero sizes act as one.
        plan.push_back('{11'd0, 11'd0, 1'b0, 1'b1, 1'b1, 20'd0, 1'b1, 4});
        // Oversize sides clamp to the largest grid; both far corners.
        plan.push_back('{11'd2047, 11'd2047, 1'b1, 1'b1, 1'b0, 20'd0, 1'b1, 3});
        plan.push_back('{11'd2047, 11'd2047, 1'b1, 1'b1, 1'b0, 20'hFFFFF, 1'b0, 3});
        plan.push_back('{11'd2047, 11'd2047, 1'b1, 1'b1, 1'b0, 20'd1023, 1'b0, -1});
        plan.push_back('{11'd1024, 11'd1024, 1'b1, 1'b1, 1'b1, 20'd0, 1'b1, -1});
        plan.push_back('{11'd1024, 11'd1024, 1'b1, 1'b1, 1'b1, 20'hFFFFF, 1'b0, -1});
        // A start on a node outside the grid still clears the edge counter.
        plan.push_back('{11'd3, 11'd3, 1'b0, 1'b1, 1'b0, 20'd9, 1'b1, 0});
        plan.push_back('{11'd3, 11'd3, 1'b0, 1'b1, 1'b0, 20'd4, 1'b0, 4});
        plan.push_back('{11'd3, 11'd3, 1'b0, 1'b0, 1'b0, 20'd0, 1'b0, 0});
        plan.push_back('{11'd3, 11'd3, 1'b0, 1'b0, 1'b0, 20'd8, 1'b1, -1});
        plan.push_back('{11'd3, 11'd3, 1'b1, 1'b0, 1'b1, 20'd0, 1'b0, -1});
        plan.push_back('{11'd3, 11'd3, 1'b1, 1'b0, 1'b1, 20'd4, 1'b1, -1});
        // A single row or column wraps onto the node itself.
        plan.push_back('{11'd5, 11'd1, 1'b1, 1'b1, 1'b1, 20'd0, 1'b1, -1});
        plan.push_back('{11'd1, 11'd4, 1'b0, 1'b1, 1'b1, 20'd3, 1'b0, -1});
        plan.push_back('{11'd1, 11'd4, 1'b0, 1'b1, 1'b1, 20'd2, 1'b1, -1});
        plan.push_back('{11'd1024, 11'd1, 1'b0, 1'b1, 1'b0, 20'd1023, 1'b0, -1});
        plan.push_back('{11'd4, 11'd3, 1'b1, 1'b0, 1'b0, 20'd5, 1'b0, -1});
        plan.push_back('{11'd4, 11'd3, 1'b0, 1'b0, 1'b1, 20'd0, 1'b0, -1});

        for (int d = 0; d < 8; d++)
            typed_links.push_back('{20'd0, DIR_W'(d), EDGE_W'(d), d == 7});
        typed_links.push_back('{20'd0, NB_N, 23'd0, 1'b0});
        typed_links.push_back('{20'd0, NB_W, 23'd1, 1'b0});
        typed_links.push_back('{20'd0, NB_E, 23'd2, 1'b0});
        typed_links.push_back('{20'd0, NB_S, 23'd3, 1'b1});
        typed_links.push_back('{20'd1, NB_E, 23'd0, 1'b0});
        typed_links.push_back('{20'd1024, NB_S, 23'd1, 1'b0});
        typed_links.push_back('{20'd1025, NB_SE, 23'd2, 1'b1});
        typed_links.push_back('{20'd1047550, NB_NW, 23'd3, 1'b0});
        typed_links.push_back('{20'd1047551, NB_N, 23'd4, 1'b0});
        typed_links.push_back('{20'd1048574, NB_W, 23'd5, 1'b1});
        typed_links.push_back('{20'd1, NB_N, 23'd0, 1'b0});
        typed_links.push_back('{20'd3, NB_W, 23'd1, 1'b0});
        typed_links.push_back('{20'd5, NB_E, 23'd2, 1'b0});
        typed_links.push_back('{20'd7, NB_S, 23'd3, 1'b1});

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            r = plan[i];
            if ({r.gw, r.gh, r.eight, r.directed, r.wrap} !=
                {cfg_width, cfg_height, cfg_eight, cfg_directed, cfg_wrap})
            begin
                settle();
                apply_config(r.gw, r.gh, r.eight, r.directed, r.wrap);
            end
            offer_node(r.node, r.start, r.n_typed);
        end

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            settle();
            apply_config(pick_side(), pick_side(), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            sender_idle_pct = SEND_IDLE[p % 4];
            stall_pct       = RECV_STALL[p % 4];
            if (p == 0)
                hold_req = 1'b1;
            repeat (NODES_PER_PHASE)
                offer_node(pick_node(), $urandom_range(0, 9) == 0, -1);
        end

        settle();
        if (mismatches == 0 && expected_links.size() == 0)
            $display("grid_neighbour_generator_unit_test passed");
        else
            $display("grid_neighbour_generator_unit_test failed");
        $finish;
    end

endmodule
